/* hdl/kcl_pkg.sv */
// Package with the shared types and constants of the keypad code lock.
package kcl_pkg;

  typedef enum logic [3:0] {
    MODE_ENTRY     = 4'b0001,
    MODE_WELCOME   = 4'b0010,
    MODE_INCORRECT = 4'b0100,
    MODE_LOCKED    = 4'b1000
  } mode_t;

  localparam logic [1:0] SCREEN_ENTRY     = 2'd0;
  localparam logic [1:0] SCREEN_WELCOME   = 2'd1;
  localparam logic [1:0] SCREEN_INCORRECT = 2'd2;
  localparam logic [1:0] SCREEN_LOCKED    = 2'd3;

  localparam logic [2:0] REG_CODE_FIRST      = 3'd0;
  localparam logic [2:0] REG_CODE_SECOND     = 3'd1;
  localparam logic [2:0] REG_CODE_THIRD      = 3'd2;
  localparam logic [2:0] REG_CODE_FOURTH     = 3'd3;
  localparam logic [2:0] REG_ERROR_LIMIT     = 3'd4;
  localparam logic [2:0] REG_WELCOME_POLLS   = 3'd5;
  localparam logic [2:0] REG_INCORRECT_POLLS = 3'd6;
  localparam logic [2:0] REG_LOCKOUT_POLLS   = 3'd7;

  localparam int          NUM_CODE_DIGITS = 4;
  localparam logic [2:0]  ROW_LAST        = 3'd4;
  localparam logic [1:0]  COL_STAR        = 2'd1;
  localparam logic [1:0]  COL_ZERO        = 2'd2;
  localparam logic [1:0]  COL_CONFIRM     = 2'd3;
  localparam logic [3:0]  TALLY_MAX       = 4'd15;

endpackage

/* hdl/keypad_code_lock_top.sv */
// Top level of the keypad code lock: configuration, poll update and result register.
// A poll's result is registered in the output register when the poll is accepted.
// One poll per cycle when ready; the state update and code compare are combinational.
// The input side stays ready while the result register is empty or being drained.
// Reset (synchronous, active high) loads the default code and hold lengths and clears
// the entry, the error count, the hold timer and the output valid flag.
module keypad_code_lock_top #(
  parameter int CODE_LENGTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // row_hit[2:0], column_hit[4:3], zero fill
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [15:0] m_tdata,  // screen_mode[1:0], digits_shown[4:2], beep_pulse[5],
                                // open_pulse[6], failed_attempts[10:7], zero fill
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import kcl_pkg::*;

  localparam int CNT_W = $clog2(CODE_LENGTH + 1);

  logic [3:0] code_digit [NUM_CODE_DIGITS];
  logic [3:0] error_limit;
  logic [7:0] welcome_polls;
  logic [7:0] incorrect_polls;
  logic [7:0] lockout_polls;

  logic [3:0]       entered_digits [CODE_LENGTH];
  logic [3:0]       entered_digits_next [CODE_LENGTH];
  logic [CNT_W-1:0] entry_count, entry_count_next;
  logic             press_consumed, press_consumed_next;
  logic             beep_done, beep_done_next;
  logic [3:0]       error_tally, error_tally_next;
  mode_t            mode_now, mode_next;
  logic [7:0]       hold_timer, hold_timer_next;

  logic [2:0] row;
  logic [1:0] col;
  logic       key, is_digit, is_confirm, match, beep, open;
  logic [3:0] digit_value, row_offset, tally_inc;
  logic [3:0] code_want [CODE_LENGTH];
  logic [1:0] screen;
  logic [3:0] count_ext;
  logic       accept;
  logic       past_valid;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;

  assign row = s_tdata[2:0];
  assign col = s_tdata[4:3];
  assign key = (row != 3'd0) && (row <= ROW_LAST) && (col != 2'd0);
  assign is_digit   = (row != ROW_LAST) || (col == COL_ZERO);
  assign is_confirm = (row == ROW_LAST) && (col == COL_CONFIRM);

  always_comb begin
    case (row)
      3'd2:    row_offset = 4'd3;
      3'd3:    row_offset = 4'd6;
      default: row_offset = 4'd0;
    endcase
    digit_value = (row == ROW_LAST) ? 4'd0 : (4'({2'b00, col}) + row_offset);
  end

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < CODE_LENGTH; i++) begin
      code_want[i] = (i < NUM_CODE_DIGITS) ? code_digit[2'(i)] : 4'd0;
      if (entered_digits[i] != code_want[i]) begin
        match = 1'b0;
      end
    end
  end

  assign tally_inc = (error_tally < TALLY_MAX) ? (error_tally + 4'd1) : error_tally;

  always_comb begin
    entered_digits_next = entered_digits;
    entry_count_next    = entry_count;
    press_consumed_next = key ? press_consumed : 1'b0;
    beep_done_next      = key ? beep_done : 1'b0;
    error_tally_next    = error_tally;
    mode_next           = mode_now;
    hold_timer_next     = hold_timer;
    beep                = 1'b0;
    open                = 1'b0;

    if (mode_now == MODE_ENTRY) begin
      if (key) begin
        if (!beep_done) begin
          beep           = 1'b1;
          beep_done_next = 1'b1;
        end
        if (is_digit && !press_consumed && (entry_count < CNT_W'(CODE_LENGTH))) begin
          for (int i = 0; i < CODE_LENGTH; i++) begin
            if (entry_count == CNT_W'(i)) begin
              entered_digits_next[i] = digit_value;
            end
          end
          entry_count_next    = entry_count + CNT_W'(1);
          press_consumed_next = 1'b1;
        end else if (is_confirm && !press_consumed &&
                     (entry_count == CNT_W'(CODE_LENGTH))) begin
          if (match) begin
            open = 1'b1;
            for (int i = 0; i < CODE_LENGTH; i++) begin
              entered_digits_next[i] = 4'd0;
            end
            mode_next       = MODE_WELCOME;
            hold_timer_next = welcome_polls;
          end else begin
            error_tally_next = tally_inc;
            if (tally_inc >= error_limit) begin
              mode_next       = MODE_LOCKED;
              hold_timer_next = lockout_polls;
            end else begin
              mode_next       = MODE_INCORRECT;
              hold_timer_next = incorrect_polls;
            end
          end
        end
      end
    end else if (hold_timer <= 8'd1) begin
      for (int i = 0; i < CODE_LENGTH; i++) begin
        entered_digits_next[i] = 4'd0;
      end
      entry_count_next    = '0;
      press_consumed_next = 1'b0;
      mode_next           = MODE_ENTRY;
      hold_timer_next     = 8'd0;
      if (mode_now != MODE_INCORRECT) begin
        beep_done_next   = 1'b0;
        error_tally_next = 4'd0;
      end
    end else begin
      hold_timer_next = hold_timer - 8'd1;
    end
  end

  always_comb begin
    case (mode_next)
      MODE_ENTRY:     screen = SCREEN_ENTRY;
      MODE_WELCOME:   screen = SCREEN_WELCOME;
      MODE_INCORRECT: screen = SCREEN_INCORRECT;
      MODE_LOCKED:    screen = SCREEN_LOCKED;
      default:        screen = SCREEN_ENTRY;
    endcase
  end

  assign count_ext = 4'(entry_count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      code_digit[0]   <= 4'd2;
      code_digit[1]   <= 4'd5;
      code_digit[2]   <= 4'd8;
      code_digit[3]   <= 4'd0;
      error_limit     <= 4'd5;
      welcome_polls   <= 8'd50;
      incorrect_polls <= 8'd10;
      lockout_polls   <= 8'd100;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CODE_FIRST:      code_digit[0]   <= cfg_data[3:0];
        REG_CODE_SECOND:     code_digit[1]   <= cfg_data[3:0];
        REG_CODE_THIRD:      code_digit[2]   <= cfg_data[3:0];
        REG_CODE_FOURTH:     code_digit[3]   <= cfg_data[3:0];
        REG_ERROR_LIMIT:     error_limit     <= cfg_data[3:0];
        REG_WELCOME_POLLS:   welcome_polls   <= cfg_data;
        REG_INCORRECT_POLLS: incorrect_polls <= cfg_data;
        REG_LOCKOUT_POLLS:   lockout_polls   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CODE_LENGTH; i++) begin
        entered_digits[i] <= 4'd0;
      end
      entry_count    <= '0;
      press_consumed <= 1'b0;
      beep_done      <= 1'b0;
      error_tally    <= 4'd0;
      mode_now       <= MODE_ENTRY;
      hold_timer     <= 8'd0;
      m_tvalid       <= 1'b0;
      past_valid     <= 1'b0;
    end else begin
      past_valid <= 1'b1;
      if (accept) begin
        entered_digits <= entered_digits_next;
        entry_count    <= entry_count_next;
        press_consumed <= press_consumed_next;
        beep_done      <= beep_done_next;
        error_tally    <= error_tally_next;
        mode_now       <= mode_next;
        hold_timer     <= hold_timer_next;
        m_tvalid       <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {5'd0, error_tally_next, open, beep, count_ext[2:0], screen};
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(CODE_LENGTH))
    else $error("Entry count exceeds the code length.");

  assert property (@(posedge clk) disable iff (rst)
    past_valid && (error_tally != $past(error_tally)) |->
      (error_tally == $past(error_tally) + 4'd1) || (error_tally == 4'd0))
    else $error("Error tally moved other than by one step or a clear.");

  assert property (@(posedge clk) disable iff (rst)
    accept && open |=> (mode_now == MODE_WELCOME) && (m_tdata[1:0] == SCREEN_WELCOME))
    else $error("A confirmed code did not enter the welcome screen.");

endmodule

/* test/tb.sv */
// Testbench for the keypad code lock: directed and random key sequences against a predictor.
`timescale 1ns / 1ps

module tb;
  import kcl_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 4;

  typedef struct packed {
    logic [1:0] screen;
    logic [2:0] shown;
    logic       beep;
    logic       opened;
    logic [3:0] fails;
  } poll_view_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 3'd0;
  logic [7:0]  cfg_data = 8'd0;

  // Register copies, at their reset values.
  logic [3:0][3:0] code_set = {4'd0, 4'd8, 4'd5, 4'd2};
  logic [3:0]      limit_reg = 4'd5;
  logic [7:0]      welcome_len = 8'd50;
  logic [7:0]      incorrect_len = 8'd10;
  logic [7:0]      lockout_len = 8'd100;

  // Lock state as the predictor tracks it.
  logic [3:0][3:0] typed_digits = '0;
  logic [2:0]      typed_count = 3'd0;
  logic            press_held = 1'b0;
  logic            beep_given = 1'b0;
  logic [3:0]      fail_tally = 4'd0;
  logic [1:0]      screen_now = SCREEN_ENTRY;
  logic [7:0]      hold_left = 8'd0;

  poll_view_t lock_views_due[$];
  int failures = 0;
  int entry_polls = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_left = 0;

  keypad_code_lock_top #(.CODE_LENGTH(NUM_CODE_DIGITS)) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic void clear_lock();
    typed_digits = '0;
    typed_count = 3'd0;
    press_held = 1'b0;
    beep_given = 1'b0;
    fail_tally = 4'd0;
    screen_now = SCREEN_ENTRY;
    hold_left = 8'd0;
  endfunction

  function automatic void advance_lock(input logic [2:0] row, input logic [1:0] col);
    logic key_down;
    logic is_digit;
    logic is_confirm;
    poll_view_t view;
    key_down = row >= 3'd1 && row <= ROW_LAST && col != 2'd0;
    view.beep = 1'b0;
    view.opened = 1'b0;
    if (!key_down) begin
      press_held = 1'b0;
      beep_given = 1'b0;
    end
    if (screen_now == SCREEN_ENTRY) begin
      if (key_down) begin
        is_digit = row < ROW_LAST || col == COL_ZERO;
        is_confirm = row == ROW_LAST && col == COL_CONFIRM;
        if (!beep_given) begin
          view.beep = 1'b1;
          beep_given = 1'b1;
        end
        if (is_digit && !press_held && typed_count < NUM_CODE_DIGITS) begin
          typed_digits[typed_count[1:0]] = (row < ROW_LAST) ? 4'(col + 3 * (row - 1)) : 4'd0;
          typed_count++;
          press_held = 1'b1;
        end else if (is_confirm && !press_held && typed_count == NUM_CODE_DIGITS) begin
          if (typed_digits == code_set) begin
            view.opened = 1'b1;
            typed_digits = '0;
            screen_now = SCREEN_WELCOME;
            hold_left = welcome_len;
          end else begin
            if (fail_tally != TALLY_MAX) fail_tally++;
            if (fail_tally >= limit_reg) begin
              screen_now = SCREEN_LOCKED;
              hold_left = lockout_len;
            end else begin
              screen_now = SCREEN_INCORRECT;
              hold_left = incorrect_len;
            end
          end
        end
      end
    end else if (hold_left <= 8'd1) begin
      if (screen_now == SCREEN_INCORRECT) begin
        typed_digits = '0;
        typed_count = 3'd0;
        press_held = 1'b0;
        screen_now = SCREEN_ENTRY;
        hold_left = 8'd0;
      end else begin
        clear_lock();
      end
    end else begin
      hold_left--;
    end
    view.screen = screen_now;
    view.shown = typed_count;
    view.fails = fail_tally;
    lock_views_due.push_back(view);
  endfunction

  function automatic void note_failure(input string what);
    failures++;
    if (failures <= 10) $display("mismatch at cycle %0d: %s", cycles, what);
  endfunction

  function automatic void check_result(input logic [15:0] word);
    poll_view_t want;
    poll_view_t got;
    got.screen = word[1:0];
    got.shown = word[4:2];
    got.beep = word[5];
    got.opened = word[6];
    got.fails = word[10:7];
    if (lock_views_due.size() == 0) begin
      note_failure($sformatf("result 0x%04h with nothing expected", word));
    end else begin
      want = lock_views_due.pop_front();
      if (got.screen != want.screen || got.shown != want.shown || got.beep != want.beep ||
          got.opened != want.opened || got.fails != want.fails)
        note_failure($sformatf(
          "expected mode %0d digits %0d beep %0b open %0b fails %0d, got %0d %0d %0b %0b %0d",
          want.screen, want.shown, want.beep, want.opened, want.fails,
          got.screen, got.shown, got.beep, got.opened, got.fails));
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_result(m_tdata);
    if (hold_off_left > 0) begin
      hold_off_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  task automatic send_poll(input logic [2:0] row, input logic [1:0] col);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, col, row};
    do @(posedge clk); while (!s_tready);
    if (screen_now == SCREEN_ENTRY) entry_polls++;
    advance_lock(row, col);
  endtask

  task automatic send_release();
    case ($urandom_range(0, 3))
      0: send_poll(3'd0, 2'd0);
      1: send_poll(3'($urandom_range(0, 7)), 2'd0);
      2: send_poll(3'd0, 2'($urandom_range(1, 3)));
      default: send_poll(3'($urandom_range(5, 7)), 2'($urandom_range(0, 3)));
    endcase
  endtask

  task automatic tap(input logic [2:0] row, input logic [1:0] col);
    int presses;
    presses = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1;
    repeat (presses) send_poll(row, col);
    repeat ($urandom_range(1, 2)) send_release();
  endtask

  task automatic tap_digit(input int d);
    if (d == 0) tap(ROW_LAST, COL_ZERO);
    else tap(3'((d - 1) / 3 + 1), 2'((d - 1) % 3 + 1));
  endtask

  task automatic wait_for_entry();
    while (screen_now != SCREEN_ENTRY) begin
      if ($urandom_range(0, 3) == 0) send_poll(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)));
      else send_release();
    end
  endtask

  task automatic try_code(input logic [15:0] code_word, input int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0) tap(ROW_LAST, COL_STAR);
      tap_digit(code_word[4 * (k % 4) +: 4]);
    end
    tap(ROW_LAST, COL_CONFIRM);
    wait_for_entry();
  endtask

  task automatic wait_results_idle();
    s_tvalid <= 1'b0;
    while (lock_views_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CODE_FIRST:      code_set[0] = value[3:0];
      REG_CODE_SECOND:     code_set[1] = value[3:0];
      REG_CODE_THIRD:      code_set[2] = value[3:0];
      REG_CODE_FOURTH:     code_set[3] = value[3:0];
      REG_ERROR_LIMIT:     limit_reg = value[3:0];
      REG_WELCOME_POLLS:   welcome_len = value;
      REG_INCORRECT_POLLS: incorrect_len = value;
      default:             lockout_len = value;
    endcase
  endtask

  task automatic load_config(input logic [15:0] code_word, input logic [3:0] limit,
                             input logic [7:0] welcome, input logic [7:0] incorrect,
                             input logic [7:0] lockout);
    wait_results_idle();
    write_reg(REG_CODE_FIRST, 8'(code_word[3:0]));
    write_reg(REG_CODE_SECOND, 8'(code_word[7:4]));
    write_reg(REG_CODE_THIRD, 8'(code_word[11:8]));
    write_reg(REG_CODE_FOURTH, 8'(code_word[15:12]));
    write_reg(REG_ERROR_LIMIT, 8'(limit));
    write_reg(REG_WELCOME_POLLS, welcome);
    write_reg(REG_INCORRECT_POLLS, incorrect);
    write_reg(REG_LOCKOUT_POLLS, lockout);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] random_code();
    logic [15:0] c;
    for (int i = 0; i < 4; i++) c[4 * i +: 4] = 4'($urandom_range(0, 9));
    return c;
  endfunction

  // Mostly complete attempts, with some broken entries and raw noise mixed in.
  task automatic run_random_phase(input int target, input int send_pct, input int recv_pct);
    int start;
    int pick;
    int idx;
    logic [15:0] guess;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    start = entry_polls;
    while (entry_polls - start < target) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        wait_results_idle();
      end else if (pick < 13) begin
        guess = code_set;
        case ($urandom_range(0, 3))
          2: begin
            idx = $urandom_range(0, 3);
            guess[4 * idx +: 4] = 4'((guess[4 * idx +: 4] + $urandom_range(1, 9)) % 10);
          end
          3: guess = random_code();
          default: ;
        endcase
        try_code(guess, NUM_CODE_DIGITS);
      end else if (pick < 16) begin
        try_code(random_code(), $urandom_range(0, 6));
      end else begin
        repeat ($urandom_range(1, 8))
          send_poll(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)));
      end
    end
    wait_results_idle();
  endtask

  // Every key kind and release form against the reset code and hold lengths.
  task automatic test_reset_defaults();
    send_poll(3'd1, 2'd1);
    send_poll(3'd1, 2'd1);
    send_poll(3'd3, 2'd0);
    send_poll(ROW_LAST, COL_STAR);
    send_poll(3'd0, 2'd0);
    send_poll(ROW_LAST, COL_ZERO);
    send_poll(3'd6, 2'd3);
    send_poll(ROW_LAST, COL_CONFIRM);
    send_poll(3'd0, 2'd2);
    send_poll(3'd3, 2'd3);
    send_poll(3'd2, 2'd2);
    send_poll(3'd7, 2'd0);
    send_poll(3'd3, 2'd2);
    send_poll(ROW_LAST, COL_CONFIRM);
    send_poll(3'd0, 2'd0);
    send_poll(3'd1, 2'd2);
    send_poll(3'd5, 2'd1);
    send_poll(ROW_LAST, COL_CONFIRM);
    send_poll(ROW_LAST, COL_CONFIRM);
    send_poll(3'd0, 2'd0);
    send_poll(3'd2, 2'd1);
    wait_for_entry();
    try_code(code_set, NUM_CODE_DIGITS);
    wait_results_idle();
  endtask

  task automatic test_hold_extremes();
    load_config({4'd9, 4'd0, 4'd9, 4'd0}, 4'd2, 8'd160, 8'd3, 8'd3);
    try_code(16'h9999, NUM_CODE_DIGITS);
    try_code(16'h4321, NUM_CODE_DIGITS);
    try_code(code_set, NUM_CODE_DIGITS);
    load_config({4'd0, 4'd9, 4'd0, 4'd9}, 4'd1, 8'd1, 8'd1, 8'd1);
    try_code(16'h0000, NUM_CODE_DIGITS);
    try_code(code_set, NUM_CODE_DIGITS);
    wait_results_idle();
  endtask

  task automatic test_random_no_idle();
    load_config(random_code(), 4'd3, 8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)),
                8'($urandom_range(1, 4)));
    run_random_phase(25, 0, 0);
  endtask

  task automatic test_random_sender_idle();
    load_config(random_code(), 4'd15, 8'd1, 8'd1, 8'd1);
    run_random_phase(25, 46, 0);
  endtask

  // The receiver holds off long enough for the output register to back up the input.
  task automatic test_random_receiver_stall();
    load_config(random_code(), 4'($urandom_range(1, 6)), 8'($urandom_range(1, 8)),
                8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)));
    hold_off_left = 80;
    run_random_phase(25, 0, 46);
  endtask

  task automatic test_random_both_idle();
    load_config(random_code(), 4'd1, 8'($urandom_range(2, 5)), 8'($urandom_range(2, 5)),
                8'($urandom_range(2, 5)));
    run_random_phase(25, 32, 32);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_hold_extremes();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    wait_results_idle();
    if (failures == 0 && lock_views_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/kcl_pkg.sv
hdl/keypad_code_lock_top.sv
test/tb.sv
